// ----- rtl/core/emb_pkg.sv -----
package emb_pkg;

	// default build-time limits
	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int DEF_MAX_CHANNELS = 4;

	// fixed field widths
	localparam int SAMPLE_W  = 8;
	localparam int ROW_OUT_W = 12;
	localparam int COL_OUT_W = 11;
	localparam int CH_OUT_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;
	localparam int CFG_WID_W = 12;
	localparam int CFG_HGT_W = 13;
	localparam int CFG_CHN_W = 3;
	localparam int ACC_W     = 13;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

	// register reset values
	localparam logic [CFG_WID_W-1:0] RST_IMAGE_WIDTH   = 12'd640;
	localparam logic [CFG_HGT_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
	localparam logic [CFG_CHN_W-1:0] RST_CHANNEL_COUNT = 3'd3;

	// clamp limits of the filtered value
	localparam logic signed [ACC_W-1:0] PIX_MIN = 13'sd0;
	localparam logic signed [ACC_W-1:0] PIX_MAX = 13'sd255;

	typedef struct packed {
		logic [SAMPLE_W-1:0]  value;
		logic [ROW_OUT_W-1:0] row;
		logic [COL_OUT_W-1:0] column;
		logic [CH_OUT_W-1:0]  channel;
		logic                 last;
	} res_t;

	// zero-extend a pixel into the signed accumulator width
	function automatic logic signed [ACC_W-1:0] pix_ext(input logic [SAMPLE_W-1:0] p);
		return $signed({{(ACC_W-SAMPLE_W){1'b0}}, p});
	endfunction

	function automatic logic [SAMPLE_W-1:0] pix_clamp(input logic signed [ACC_W-1:0] a);
		logic [SAMPLE_W-1:0] r;
		if (a < PIX_MIN) begin
			r = '0;
		end else if (a > PIX_MAX) begin
			r = '1;
		end else begin
			r = a[SAMPLE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/emboss_3x3_filter_core.sv -----
// emboss 3x3 filter core, one channel sample per beat, raster order
// a sample beat is registered in stage 1, then its results in the output register
// one sample per cycle while results are taken; a sample that yields two results
// (an interior pixel plus a border pixel) holds the input until both are taken
// reset: arst_n clears the pipeline, the position and the registers to
// 640 x 480 x 3 at once; line stores and window taps are not cleared
module emboss_3x3_filter_core #(
	parameter int MAX_WIDTH    = emb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT   = emb_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_CHANNELS = emb_pkg::DEF_MAX_CHANNELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample channel
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  logic [emb_pkg::SAMPLE_W-1:0]    sample,
	input  logic                            frame_start,
	// result channel
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [emb_pkg::SAMPLE_W-1:0]    value,
	output logic [emb_pkg::ROW_OUT_W-1:0]   row,
	output logic [emb_pkg::COL_OUT_W-1:0]   column,
	output logic [emb_pkg::CH_OUT_W-1:0]    channel,
	output logic                            last_of_run,
	// register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [emb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [emb_pkg::CFG_DAT_W-1:0]   cfg_data
);

	// position and store geometry
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ROWP_W     = $clog2(MAX_HEIGHT + 1);
	localparam int COLP_W     = $clog2(MAX_WIDTH + 1);
	localparam int CHP_W      = $clog2(MAX_CHANNELS + 1);
	localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int ADDR_W     = $clog2(LINE_DEPTH);

	// ------------------------------------------------------------------
	// registers
	// ------------------------------------------------------------------
	logic [emb_pkg::CFG_WID_W-1:0] cfg_width_q;
	logic [emb_pkg::CFG_HGT_W-1:0] cfg_height_q;
	logic [emb_pkg::CFG_CHN_W-1:0] cfg_chans_q;

	// writes are taken in any cycle; the user writes only while idle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q  <= emb_pkg::RST_IMAGE_WIDTH;
			cfg_height_q <= emb_pkg::RST_IMAGE_HEIGHT;
			cfg_chans_q  <= emb_pkg::RST_CHANNEL_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				emb_pkg::REG_IMAGE_WIDTH: begin
					cfg_width_q <= cfg_data[emb_pkg::CFG_WID_W-1:0];
				end
				emb_pkg::REG_IMAGE_HEIGHT: begin
					cfg_height_q <= cfg_data[emb_pkg::CFG_HGT_W-1:0];
				end
				emb_pkg::REG_CHANNEL_COUNT: begin
					cfg_chans_q <= cfg_data[emb_pkg::CFG_CHN_W-1:0];
				end
				default: begin
					// index beyond the register list is dropped
				end
			endcase
		end
	end

	// effective image size: zero reads as one, large values saturate
	logic [COLP_W-1:0] w_eff;
	logic [ROWP_W-1:0] h_eff;
	logic [CHP_W-1:0]  nc_eff;

	always_comb begin
		if (cfg_width_q == '0) begin
			w_eff = COLP_W'(1);
		end else if (32'(cfg_width_q) > MAX_WIDTH) begin
			w_eff = COLP_W'(MAX_WIDTH);
		end else begin
			w_eff = COLP_W'(cfg_width_q);
		end
		if (cfg_height_q == '0) begin
			h_eff = ROWP_W'(1);
		end else if (32'(cfg_height_q) > MAX_HEIGHT) begin
			h_eff = ROWP_W'(MAX_HEIGHT);
		end else begin
			h_eff = ROWP_W'(cfg_height_q);
		end
		if (cfg_chans_q == '0) begin
			nc_eff = CHP_W'(1);
		end else if (32'(cfg_chans_q) > MAX_CHANNELS) begin
			nc_eff = CHP_W'(MAX_CHANNELS);
		end else begin
			nc_eff = CHP_W'(cfg_chans_q);
		end
	end

	// ------------------------------------------------------------------
	// input side: raster position and line store read
	// ------------------------------------------------------------------
	logic              in_acc;
	logic              s1_go;
	logic              s1_valid_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [CH_W-1:0]   ch_q;
	logic [ROW_W-1:0]  base_r;
	logic [COL_W-1:0]  base_c;
	logic [CH_W-1:0]   base_ch;
	logic              ch_wrap, col_wrap, row_wrap;
	logic [ADDR_W-1:0] idx_in;

	assign in_acc       = sample_valid && !sample_stall;
	// stage 1 holds its beat until the output register can take the results
	assign sample_stall = s1_valid_q && !s1_go;

	// frame_start moves the position to the origin before the beat is used
	assign base_r  = frame_start ? '0 : row_q;
	assign base_c  = frame_start ? '0 : col_q;
	assign base_ch = frame_start ? '0 : ch_q;

	assign ch_wrap  = (32'(base_ch) + 32'd1) >= 32'(nc_eff);
	assign col_wrap = (32'(base_c) + 32'd1) >= 32'(w_eff);
	assign row_wrap = (32'(base_r) + 32'd1) >= 32'(h_eff);

	// channels of one column sit next to each other in the line stores
	assign idx_in = ADDR_W'(32'(base_c) * MAX_CHANNELS + 32'(base_ch));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (in_acc) begin
			if (ch_wrap) begin
				ch_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					// after the last row the position wraps to the origin
					row_q <= row_wrap ? '0 : base_r + ROW_W'(1);
				end else begin
					col_q <= base_c + COL_W'(1);
					row_q <= base_r;
				end
			end else begin
				ch_q  <= base_ch + CH_W'(1);
				col_q <= base_c;
				row_q <= base_r;
			end
		end
	end

	// stage 1 beat
	logic [emb_pkg::SAMPLE_W-1:0] sample_s1;
	logic [ROW_W-1:0]             r_s1;
	logic [COL_W-1:0]             c_s1;
	logic [CH_W-1:0]              ch_s1;
	logic [ADDR_W-1:0]            idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= sample;
			r_s1      <= base_r;
			c_s1      <= base_c;
			ch_s1     <= base_ch;
			idx_s1    <= idx_in;
		end
	end

	// ------------------------------------------------------------------
	// line stores: read when a beat is taken, written when it leaves stage 1
	// ------------------------------------------------------------------
	logic [emb_pkg::SAMPLE_W-1:0] upper_mem  [LINE_DEPTH];
	logic [emb_pkg::SAMPLE_W-1:0] middle_mem [LINE_DEPTH];
	logic [emb_pkg::SAMPLE_W-1:0] u_rd_s1, m_rd_s1;
	logic [emb_pkg::SAMPLE_W-1:0] u_eff, m_eff;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_rd_s1 <= upper_mem[idx_in];
			m_rd_s1 <= middle_mem[idx_in];
		end
		if (s1_go) begin
			// rows shift up by one: the middle line moves to the upper line
			upper_mem[idx_s1]  <= m_eff;
			middle_mem[idx_s1] <= sample_s1;
		end
	end

	// the read at the same edge as a write to the same entry sees old data,
	// so the new contents are carried alongside
	logic                         fwd_s1;
	logic [emb_pkg::SAMPLE_W-1:0] fwd_u_s1, fwd_m_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= 1'b0;
		end else if (in_acc) begin
			fwd_s1 <= s1_go && (idx_in == idx_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			fwd_u_s1 <= m_eff;
			fwd_m_s1 <= sample_s1;
		end
	end

	assign u_eff = fwd_s1 ? fwd_u_s1 : u_rd_s1;
	assign m_eff = fwd_s1 ? fwd_m_s1 : m_rd_s1;

	// ------------------------------------------------------------------
	// window taps: [column][row][channel], column 0 is c-1, column 1 is c-2
	// ------------------------------------------------------------------
	logic [emb_pkg::SAMPLE_W-1:0] win_q [2][3][MAX_CHANNELS];

	always_ff @(posedge clk) begin
		if (s1_go) begin
			for (int k = 0; k < 3; k++) begin
				win_q[1][k][ch_s1] <= win_q[0][k][ch_s1];
			end
			win_q[0][0][ch_s1] <= u_eff;
			win_q[0][1][ch_s1] <= m_eff;
			win_q[0][2][ch_s1] <= sample_s1;
		end
	end

	// ------------------------------------------------------------------
	// kernel and result selection
	// ------------------------------------------------------------------
	logic signed [emb_pkg::ACC_W-1:0] acc;
	logic                             interior, border;
	emb_pkg::res_t                    res_flt, res_pass;
	logic [1:0]                       n_res;

	// kernel -2 -1 0 / -1 1 1 / 0 1 2, sum lies within -1020..1275
	always_comb begin
		acc = (emb_pkg::pix_ext(sample_s1) <<< 1)
			+ emb_pkg::pix_ext(m_eff)
			+ emb_pkg::pix_ext(win_q[0][2][ch_s1])
			+ emb_pkg::pix_ext(win_q[0][1][ch_s1])
			- emb_pkg::pix_ext(win_q[0][0][ch_s1])
			- emb_pkg::pix_ext(win_q[1][1][ch_s1])
			- (emb_pkg::pix_ext(win_q[1][0][ch_s1]) <<< 1);
	end

	// this beat closes the window of the pixel one row up, one column left
	assign interior = (32'(r_s1) >= 32'd2) && (32'(c_s1) >= 32'd2)
		&& (32'(r_s1) < 32'(h_eff)) && (32'(c_s1) < 32'(w_eff));
	// this beat belongs to a border pixel (also any position past the size)
	assign border = !((32'(r_s1) >= 32'd1) && (32'(c_s1) >= 32'd1)
		&& (32'(r_s1) + 32'd2 <= 32'(h_eff)) && (32'(c_s1) + 32'd2 <= 32'(w_eff)));

	always_comb begin
		res_flt.value   = emb_pkg::pix_clamp(acc);
		res_flt.row     = emb_pkg::ROW_OUT_W'(r_s1 - ROW_W'(1));
		res_flt.column  = emb_pkg::COL_OUT_W'(c_s1 - COL_W'(1));
		res_flt.channel = emb_pkg::CH_OUT_W'(ch_s1);
		res_flt.last    = !border;
		res_pass.value   = sample_s1;
		res_pass.row     = emb_pkg::ROW_OUT_W'(r_s1);
		res_pass.column  = emb_pkg::COL_OUT_W'(c_s1);
		res_pass.channel = emb_pkg::CH_OUT_W'(ch_s1);
		res_pass.last    = 1'b1;
	end

	assign n_res = {1'b0, interior} + {1'b0, border};

	// ------------------------------------------------------------------
	// output register: up to two result beats, head first
	// ------------------------------------------------------------------
	logic [1:0]    out_cnt_q;
	emb_pkg::res_t res0_q, res1_q;
	logic          out_acc;

	assign result_valid = (out_cnt_q != 2'd0);
	assign out_acc      = result_valid && !result_stall;
	// new results load when the register is empty or empties in this cycle
	assign s1_go = s1_valid_q
		&& ((out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && out_acc));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (s1_go) begin
			out_cnt_q <= n_res;
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			// filtered interior value goes ahead of the border sample
			res0_q <= interior ? res_flt : res_pass;
			res1_q <= res_pass;
		end else if (out_acc) begin
			res0_q <= res1_q;
		end
	end

	assign value       = res0_q.value;
	assign row         = res0_q.row;
	assign column      = res0_q.column;
	assign channel     = res0_q.channel;
	assign last_of_run = res0_q.last;

`ifndef SYNTHESIS
	// the input only stalls behind a held stage 1 beat
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> s1_valid_q)
		else $error("input stalled with stage 1 empty");

	// a held stage 1 beat keeps its store address
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_go) |=> (s1_valid_q && $stable(idx_s1)))
		else $error("stage 1 beat lost or changed while held");

	// with two results queued the head never closes the run
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q == 2'd2) |-> (!res0_q.last && res1_q.last))
		else $error("result pair out of order");

	// forwarded store data only follows a store write at the read edge
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fwd_s1) |-> $past(s1_go))
		else $error("store forwarding without a write");

	// results are never overwritten before they are taken
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go |-> ((out_cnt_q == 2'd0) || out_acc))
		else $error("output register overrun");
`endif

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	// size limits of the block as built
	localparam int unsigned MAX_W  = emb_pkg::DEF_MAX_WIDTH;
	localparam int unsigned MAX_H  = emb_pkg::DEF_MAX_HEIGHT;
	localparam int unsigned MAX_CH = emb_pkg::DEF_MAX_CHANNELS;
	localparam int unsigned LINE_DEPTH = MAX_W * MAX_CH;

	// index 3 is not a register, writes to it must be ignored
	localparam logic [emb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// cycles to let the pipeline settle once nothing is due
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;

	typedef struct {
		logic [emb_pkg::SAMPLE_W-1:0] pix;
		logic                         first;
		bit                           hold;   // wait until every due result has come
	} sample_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// sample channel
	logic                          sample_valid = 1'b0;
	logic                          sample_stall;
	logic [emb_pkg::SAMPLE_W-1:0]  sample = '0;
	logic                          frame_start = 1'b0;

	// result channel
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [emb_pkg::SAMPLE_W-1:0]  value;
	logic [emb_pkg::ROW_OUT_W-1:0] row;
	logic [emb_pkg::COL_OUT_W-1:0] column;
	logic [emb_pkg::CH_OUT_W-1:0]  channel;
	logic                          last_of_run;

	// register write channel
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [emb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [emb_pkg::CFG_DAT_W-1:0] cfg_data = '0;

	// beats waiting to be driven and results still to arrive
	sample_beat_t  samples_to_send [$];
	emb_pkg::res_t pixel_results_due [$];
	sample_beat_t  beat;
	emb_pkg::res_t want;

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_idle_pct = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int unsigned random_beats = 0;

	// shadow of the register file, raw as written
	int unsigned reg_width   = emb_pkg::RST_IMAGE_WIDTH;
	int unsigned reg_height  = emb_pkg::RST_IMAGE_HEIGHT;
	int unsigned reg_chans   = emb_pkg::RST_CHANNEL_COUNT;

	// shadow of the line stores, window taps and raster position
	logic [emb_pkg::SAMPLE_W-1:0] upper_line_sh [LINE_DEPTH];
	logic [emb_pkg::SAMPLE_W-1:0] middle_line_sh [LINE_DEPTH];
	logic [emb_pkg::SAMPLE_W-1:0] taps [2][3][MAX_CH];
	int unsigned pos_row = 0;
	int unsigned pos_col = 0;
	int unsigned pos_ch  = 0;

	emboss_3x3_filter_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.frame_start  (frame_start),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.value        (value),
		.row          (row),
		.column       (column),
		.channel      (channel),
		.last_of_run  (last_of_run),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// zero reads as one, anything above the build limit saturates
	function automatic int unsigned sat_reg(input int unsigned v, input int unsigned maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	// expected results of one accepted sample beat, interior result first
	task automatic predict_emboss(input logic [emb_pkg::SAMPLE_W-1:0] pix, input logic first);
		int unsigned w, h, nc, idx;
		int acc;
		logic [emb_pkg::SAMPLE_W-1:0] up, mid;
		bit filtered, border;
		emb_pkg::res_t due;
		w  = sat_reg(reg_width, MAX_W);
		h  = sat_reg(reg_height, MAX_H);
		nc = sat_reg(reg_chans, MAX_CH);
		if (first) begin
			pos_row = 0;
			pos_col = 0;
			pos_ch  = 0;
		end
		idx = pos_col * MAX_CH + pos_ch;
		up  = upper_line_sh[idx];
		mid = middle_line_sh[idx];

		// this sample closes the window centered one row up, one column left
		filtered = pos_row >= 2 && pos_col >= 2 && pos_row <= h - 1 && pos_col <= w - 1;
		// first or last row or column, or outside the current size
		border = !(pos_row >= 1 && pos_col >= 1 && pos_row + 2 <= h && pos_col + 2 <= w);

		if (filtered) begin
			acc = -2 * int'(taps[1][0][pos_ch]) - int'(taps[0][0][pos_ch])
				- int'(taps[1][1][pos_ch]) + int'(taps[0][1][pos_ch]) + int'(mid)
				+ int'(taps[0][2][pos_ch]) + 2 * int'(pix);
			if (acc < 0)
				acc = 0;
			if (acc > 255)
				acc = 255;
			due.value   = acc[emb_pkg::SAMPLE_W-1:0];
			due.row     = emb_pkg::ROW_OUT_W'(pos_row - 1);
			due.column  = emb_pkg::COL_OUT_W'(pos_col - 1);
			due.channel = emb_pkg::CH_OUT_W'(pos_ch);
			due.last    = !border;
			pixel_results_due.push_back(due);
		end
		if (border) begin
			due.value   = pix;
			due.row     = emb_pkg::ROW_OUT_W'(pos_row);
			due.column  = emb_pkg::COL_OUT_W'(pos_col);
			due.channel = emb_pkg::CH_OUT_W'(pos_ch);
			due.last    = 1'b1;
			pixel_results_due.push_back(due);
		end

		// shift the window one column and roll the line stores down
		for (int k = 0; k < 3; k++)
			taps[1][k][pos_ch] = taps[0][k][pos_ch];
		taps[0][0][pos_ch] = up;
		taps[0][1][pos_ch] = mid;
		taps[0][2][pos_ch] = pix;
		upper_line_sh[idx]  = mid;
		middle_line_sh[idx] = pix;

		// raster advance, wraps to the origin after the last sample
		pos_ch++;
		if (pos_ch >= nc) begin
			pos_ch = 0;
			pos_col++;
			if (pos_col >= w) begin
				pos_col = 0;
				pos_row++;
				if (pos_row >= h)
					pos_row = 0;
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	// sample driver: a new beat only once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				predict_emboss(sample, frame_start);
			if (!sample_valid || !sample_stall) begin
				if (samples_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct
					&& !(samples_to_send[0].hold && pixel_results_due.size() != 0)) begin
					beat = samples_to_send.pop_front();
					sample_valid <= 1'b1;
					sample       <= beat.pix;
					frame_start  <= beat.first;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each taken beat with the oldest due result
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (pixel_results_due.size() == 0) begin
					$error("unexpected result beat: value %0d row %0d column %0d channel %0d",
						value, row, column, channel);
					fail_count++;
				end else begin
					want = pixel_results_due.pop_front();
					check_field("value", want.value, value);
					check_field("row", want.row, row);
					check_field("column", want.column, column);
					check_field("channel", want.channel, channel);
					check_field("last_of_run", want.last, last_of_run);
				end
			end
			result_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic queue_beat(input logic [emb_pkg::SAMPLE_W-1:0] pix, input logic first,
		input bit hold);
		sample_beat_t b;
		b.pix   = pix;
		b.first = first;
		b.hold  = hold;
		samples_to_send.push_back(b);
	endtask

	// all beats sent, all results in, then a settling wait for zero-result samples
	task automatic wait_idle();
		do
			@(negedge clk);
		while (samples_to_send.size() != 0 || sample_valid || pixel_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// called in a posedge step; leaves cfg_valid high for a following write
	task automatic write_reg(input logic [emb_pkg::CFG_IDX_W-1:0] idx,
		input logic [emb_pkg::CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			emb_pkg::REG_IMAGE_WIDTH:   reg_width  = data[emb_pkg::CFG_WID_W-1:0];
			emb_pkg::REG_IMAGE_HEIGHT:  reg_height = data[emb_pkg::CFG_HGT_W-1:0];
			emb_pkg::REG_CHANNEL_COUNT: reg_chans  = data[emb_pkg::CFG_CHN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_regs(input int unsigned w, input int unsigned h, input int unsigned nc);
		write_reg(emb_pkg::REG_IMAGE_WIDTH, emb_pkg::CFG_DAT_W'(w));
		write_reg(emb_pkg::REG_IMAGE_HEIGHT, emb_pkg::CFG_DAT_W'(h));
		write_reg(emb_pkg::REG_CHANNEL_COUNT, emb_pkg::CFG_DAT_W'(nc));
		cfg_valid <= 1'b0;
	endtask

	// two in ten zeros and two in ten full scale to drive the clamp, the rest uniform
	function automatic logic [emb_pkg::SAMPLE_W-1:0] rand_pixel();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick < 2)
			return 8'h00;
		if (pick < 4)
			return 8'hFF;
		return emb_pkg::SAMPLE_W'($urandom_range(255));
	endfunction

	function automatic int unsigned rand_dim(input int unsigned top);
		if ($urandom_range(9) == 0)
			return $urandom_range(1, 2);
		return $urandom_range(3, top);
	endfunction

	// one setting: whole images with random content, some cut short,
	// some started by wrap instead of frame_start
	task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned nc,
		input int unsigned budget);
		int unsigned full, len, n;
		bit whole, first;
		wait_idle();
		write_regs(w, h, nc);
		full = sat_reg(w % 4096, MAX_W) * sat_reg(h % 8192, MAX_H) * sat_reg(nc % 8, MAX_CH);
		n = 0;
		whole = 1'b0;
		while (n < budget) begin
			len = full;
			if (len > budget - n)
				len = budget - n;
			if (len > 1 && $urandom_range(99) < 15)
				len = $urandom_range(1, len - 1);
			first = !(whole && $urandom_range(99) < 30);
			for (int k = 0; k < len; k++)
				queue_beat(rand_pixel(), k == 0 && first, k == 0 && $urandom_range(19) == 0);
			whole = (len == full);
			n += len;
		end
		random_beats += n;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles often, receiver stalls more
		sender_idle_pct   = 33;
		receiver_idle_pct = 72;

		// reset size: row 0 passes through, sample extremes
		queue_beat(8'h00, 1'b1, 1'b0);
		queue_beat(8'hFF, 1'b0, 1'b0);

		// 3x3 two-channel image: one interior pixel per channel, channel 0
		// drives the sum below zero, channel 1 above full scale; the last
		// pixel brings filtered result and border pass-through together
		wait_idle();
		write_reg(REG_UNUSED, '1);
		write_regs(3, 3, 2);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++) begin
				queue_beat((r + c < 2) ? 8'hFF : 8'h00, r == 0 && c == 0, 1'b0);
				queue_beat((r + c < 2) ? 8'h00 : 8'hFF, 1'b0, 1'b0);
			end
		// position wraps to the origin with no frame_start; hold off until
		// every result of the image is back
		queue_beat(8'h7E, 1'b0, 1'b1);

		// single-column image, then the height shrinks under the position:
		// the row beyond the new size passes through and wraps to row 0
		wait_idle();
		write_regs(1, 5, 1);
		for (int k = 0; k < 4; k++)
			queue_beat(emb_pkg::SAMPLE_W'(8'h81 + k), k == 0, 1'b0);
		wait_idle();
		write_reg(emb_pkg::REG_IMAGE_HEIGHT, emb_pkg::CFG_DAT_W'(2));
		cfg_valid <= 1'b0;
		queue_beat(8'h3C, 1'b0, 1'b0);
		queue_beat(8'hC3, 1'b0, 1'b0);

		// register extremes: zeros, saturation above the limits, exact limits
		run_phase(0, 0, 0, 12);
		run_phase(4095, 8191, 7, 24);
		run_phase(2048, 4096, 4, 24);
		run_phase(3, 4096, 1, 60);

		while (random_beats < 170)
			run_phase(rand_dim(7), rand_dim(6), $urandom_range(1, 4), $urandom_range(30, 90));

		// swap: receiver stalls less, sender idles more
		sender_idle_pct   = 72;
		receiver_idle_pct = 33;
		while (random_beats < 340)
			run_phase(rand_dim(7), rand_dim(6), $urandom_range(1, 4), $urandom_range(30, 90));

		// full rate on both sides
		sender_idle_pct   = 0;
		receiver_idle_pct = 0;
		while (random_beats < 500)
			run_phase(rand_dim(7), rand_dim(6), $urandom_range(1, 4), $urandom_range(30, 90));

		wait_idle();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/emb_pkg.sv
rtl/core/emboss_3x3_filter_core.sv
verif/testbench.sv
